[src/sgps_pkg.sv]
// shared constants, codes and beat types of the scatter-gather piece splitter
package sgps_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int SIZE_BITS    = 32;
    localparam int MAX_PIECES   = 32;

    localparam int ADDR_W      = 36;
    localparam int COUNT_W     = 5;
    localparam int SLOT_W      = 4;
    localparam int SEG_OUT_W   = 4;
    localparam int OUT_OFF_W   = 32;
    localparam int PEER_W      = 16;
    localparam int BYTES_W     = 32;
    localparam int CFG_INDEX_W = 2;

    localparam int IDX_W       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEG_CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int SUM_W       = SIZE_BITS + $clog2(MAX_SEGMENTS);
    localparam int OFF_W       = (SIZE_BITS > ADDR_W) ? SIZE_BITS : ADDR_W;
    localparam int CMP_W       = (SUM_W > ADDR_W + 1) ? SUM_W : ADDR_W + 1;
    localparam int PIECE_CNT_W = $clog2(MAX_PIECES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_LOAD_REMOTE = 2'd0;
    localparam logic [1:0] OP_LOAD_LOCAL  = 2'd1;
    localparam logic [1:0] OP_TRANSFER    = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_OVER_REMOTE = 2'd1;
    localparam logic [1:0] STATUS_OVER_LOCAL  = 2'd2;
    localparam logic [1:0] STATUS_ZERO_LENGTH = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_COUNT  = 2'd1;

    typedef enum logic [1:0] {
        CMD_LOAD_REMOTE = 2'd0,
        CMD_LOAD_LOCAL  = 2'd1,
        CMD_TRANSFER    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [SLOT_W-1:0]        slot;
        logic [SIZE_BITS-1:0]     bytes;
        logic                     dir;
        logic [PEER_W-1:0]        peer;
        logic [ADDR_W-1:0]        rstart;
        logic [ADDR_W-1:0]        lstart;
        logic [ADDR_W-1:0]        len;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     dir;
        logic [PEER_W-1:0]        peer;
        logic [SEG_OUT_W-1:0]     rseg;
        logic [OUT_OFF_W-1:0]     roff;
        logic [SEG_OUT_W-1:0]     lseg;
        logic [OUT_OFF_W-1:0]     loff;
        logic [OUT_OFF_W-1:0]     len;
        logic                     last;
    } piece_t;

endpackage

[src/scatter_gather_piece_splitter_unit.sv]
// top level of the scatter-gather piece splitter: front end, command queue, piece engine
//
// Requests enter through a front end and a two-entry command queue, so new beats are
// taken while the piece engine is busy, until the queue fills. A segment-size load is
// written to its table as the idle engine takes it from the queue. A transfer is taken
// from the queue, then makes one pass over both size tables, which forms the list
// totals and translates both start offsets, then goes through the range checks; an
// error or a zero length gives a single result. Each piece then goes through size,
// advance and boundary check, stepping past every segment boundary crossed on both
// lists, and is then handed to the output register; the walk waits while the output
// stalls. The block works on one transfer at a time, limited by the single read port
// of each table. Segment counts are written through the configuration port and take
// effect at once, also mid-transfer; size tables hold nothing until loaded.
module scatter_gather_piece_splitter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic [sgps_pkg::SLOT_W-1:0]         segment_slot,
    input  logic [sgps_pkg::BYTES_W-1:0]        segment_bytes,
    input  logic                                direction,
    input  logic [sgps_pkg::PEER_W-1:0]         peer_id,
    input  logic [sgps_pkg::ADDR_W-1:0]         remote_start,
    input  logic [sgps_pkg::ADDR_W-1:0]         local_start,
    input  logic [sgps_pkg::ADDR_W-1:0]         transfer_length,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic                                piece_direction,
    output logic [sgps_pkg::PEER_W-1:0]         piece_peer,
    output logic [sgps_pkg::SEG_OUT_W-1:0]      remote_segment,
    output logic [sgps_pkg::OUT_OFF_W-1:0]      remote_seg_offset,
    output logic [sgps_pkg::SEG_OUT_W-1:0]      local_segment,
    output logic [sgps_pkg::OUT_OFF_W-1:0]      local_seg_offset,
    output logic [sgps_pkg::OUT_OFF_W-1:0]      piece_length,
    output logic                                last_piece,
    input  logic                                cfg_write,
    input  logic [sgps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sgps_pkg::COUNT_W-1:0]        cfg_data
);

    logic             push;
    sgps_pkg::cmd_t   push_data;
    logic             q_full;
    logic             q_valid;
    sgps_pkg::cmd_t   q_head;
    logic             q_pop;
    sgps_pkg::piece_t piece;

    sgps_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .segment_slot    (segment_slot),
        .segment_bytes   (segment_bytes),
        .direction       (direction),
        .peer_id         (peer_id),
        .remote_start    (remote_start),
        .local_start     (local_start),
        .transfer_length (transfer_length),
        .push            (push),
        .push_data       (push_data),
        .q_full          (q_full)
    );

    sgps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head),
        .pop       (q_pop)
    );

    sgps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_piece (piece)
    );

    assign status            = piece.status;
    assign piece_direction   = piece.dir;
    assign piece_peer        = piece.peer;
    assign remote_segment    = piece.rseg;
    assign remote_seg_offset = piece.roff;
    assign local_segment     = piece.lseg;
    assign local_seg_offset  = piece.loff;
    assign piece_length      = piece.len;
    assign last_piece        = piece.last;

endmodule

[src/sgps_front.sv]
// front end: takes request beats, sorts them into commands, drops the ones that do nothing
module sgps_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [sgps_pkg::SLOT_W-1:0]   segment_slot,
    input  logic [sgps_pkg::BYTES_W-1:0]  segment_bytes,
    input  logic                          direction,
    input  logic [sgps_pkg::PEER_W-1:0]   peer_id,
    input  logic [sgps_pkg::ADDR_W-1:0]   remote_start,
    input  logic [sgps_pkg::ADDR_W-1:0]   local_start,
    input  logic [sgps_pkg::ADDR_W-1:0]   transfer_length,
    output logic                          push,
    output sgps_pkg::cmd_t                push_data,
    input  logic                          q_full
);

    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    sgps_pkg::cmd_t cmd_reg;
    sgps_pkg::cmd_t cmd_next;
    logic           accept;
    logic           keep;
    logic           slot_ok;

    assign in_stall  = cmd_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = cmd_valid_reg;
    assign push_data = cmd_reg;
    assign slot_ok   = 32'(segment_slot) < sgps_pkg::MAX_SEGMENTS;

    always_comb
    begin
        cmd_next        = cmd_reg;
        keep            = 1'b0;
        cmd_next.slot   = segment_slot;
        cmd_next.bytes  = sgps_pkg::SIZE_BITS'(segment_bytes);
        cmd_next.dir    = direction;
        cmd_next.peer   = peer_id;
        cmd_next.rstart = remote_start;
        cmd_next.lstart = local_start;
        cmd_next.len    = transfer_length;
        case (opcode)
            sgps_pkg::OP_LOAD_REMOTE:
            begin
                cmd_next.kind = sgps_pkg::CMD_LOAD_REMOTE;
                keep          = accept && slot_ok;
            end
            sgps_pkg::OP_LOAD_LOCAL:
            begin
                cmd_next.kind = sgps_pkg::CMD_LOAD_LOCAL;
                keep          = accept && slot_ok;
            end
            sgps_pkg::OP_TRANSFER:
            begin
                cmd_next.kind = sgps_pkg::CMD_TRANSFER;
                keep          = accept;
            end
            default:
            begin
                // unused opcode is swallowed
                keep = 1'b0;
            end
        endcase
        cmd_valid_next = keep || (cmd_valid_reg && q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[src/sgps_queue.sv]
// short command queue between the front end and the piece engine
module sgps_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sgps_pkg::cmd_t push_data,
    output logic           full,
    output logic           valid,
    output sgps_pkg::cmd_t head,
    input  logic           pop
);

    sgps_pkg::cmd_t                         entries [sgps_pkg::QUEUE_DEPTH];
    logic [sgps_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [sgps_pkg::QUEUE_PTR_W-1:0]       wr_ptr_next;
    logic [sgps_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [sgps_pkg::QUEUE_PTR_W-1:0]       rd_ptr_next;
    logic [sgps_pkg::QUEUE_CNT_W-1:0]       count_reg;
    logic [sgps_pkg::QUEUE_CNT_W-1:0]       count_next;
    logic                                   do_push;
    logic                                   do_pop;

    assign full    = count_reg == sgps_pkg::QUEUE_CNT_W'(sgps_pkg::QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign head    = entries[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == sgps_pkg::QUEUE_PTR_W'(sgps_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == sgps_pkg::QUEUE_PTR_W'(sgps_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/sgps_back.sv]
// piece engine: segment tables, offset translation, range checks and piece walk
module sgps_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  sgps_pkg::cmd_t                      q_data,
    output logic                                q_pop,
    input  logic                                cfg_write,
    input  logic [sgps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sgps_pkg::COUNT_W-1:0]        cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sgps_pkg::piece_t                    out_piece
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SUM   = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_EMIT  = 7'b0001000,
        ST_ADV   = 7'b0010000,
        ST_SKIP  = 7'b0100000,
        ST_PUSH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [sgps_pkg::COUNT_W-1:0]     rcount_reg, lcount_reg;
    logic [sgps_pkg::SIZE_BITS-1:0]   rsizes [sgps_pkg::MAX_SEGMENTS];
    logic [sgps_pkg::SIZE_BITS-1:0]   lsizes [sgps_pkg::MAX_SEGMENTS];

    logic                             dir_reg, dir_next;
    logic [sgps_pkg::PEER_W-1:0]      peer_reg, peer_next;
    logic [sgps_pkg::ADDR_W-1:0]      rstart_reg, rstart_next;
    logic [sgps_pkg::ADDR_W-1:0]      lstart_reg, lstart_next;
    logic [sgps_pkg::ADDR_W-1:0]      len_reg, len_next;
    logic [sgps_pkg::IDX_W-1:0]       step_reg, step_next;
    logic [sgps_pkg::SUM_W-1:0]       rsum_reg, rsum_next;
    logic [sgps_pkg::SUM_W-1:0]       lsum_reg, lsum_next;
    logic                             rfound_reg, rfound_next;
    logic                             lfound_reg, lfound_next;
    logic [sgps_pkg::OFF_W-1:0]       rloc_reg, rloc_next;
    logic [sgps_pkg::OFF_W-1:0]       lloc_reg, lloc_next;
    logic [sgps_pkg::SEG_CNT_W-1:0]   ri_reg, ri_next;
    logic [sgps_pkg::SEG_CNT_W-1:0]   li_reg, li_next;
    logic [sgps_pkg::SIZE_BITS-1:0]   ro_reg, ro_next;
    logic [sgps_pkg::SIZE_BITS-1:0]   lo_reg, lo_next;
    logic [sgps_pkg::ADDR_W-1:0]      rem_reg, rem_next;
    logic [sgps_pkg::SIZE_BITS-1:0]   t_reg, t_next;
    logic [sgps_pkg::PIECE_CNT_W-1:0] k_reg, k_next;
    logic                             more_reg, more_next;
    sgps_pkg::piece_t                 pend_reg, pend_next;
    sgps_pkg::piece_t                 out_piece_reg;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_load;

    logic [sgps_pkg::SEG_CNT_W-1:0]   rused, lused;
    logic [sgps_pkg::IDX_W-1:0]       r_rd_idx, l_rd_idx;
    logic [sgps_pkg::SIZE_BITS-1:0]   r_size, l_size;
    logic                             ractive, lactive;
    logic [sgps_pkg::SIZE_BITS-1:0]   ra, la, tmin, tpiece;
    logic [sgps_pkg::ADDR_W:0]        rend, lend;
    logic                             r_skip, l_skip, cont;
    logic                             load_remote, load_local;

    assign rused = (32'(rcount_reg) > sgps_pkg::MAX_SEGMENTS)
                   ? sgps_pkg::SEG_CNT_W'(sgps_pkg::MAX_SEGMENTS)
                   : sgps_pkg::SEG_CNT_W'(rcount_reg);
    assign lused = (32'(lcount_reg) > sgps_pkg::MAX_SEGMENTS)
                   ? sgps_pkg::SEG_CNT_W'(sgps_pkg::MAX_SEGMENTS)
                   : sgps_pkg::SEG_CNT_W'(lcount_reg);

    // one read port per table: the step counter while summing, the walk index after
    assign r_rd_idx = (state_reg == ST_SUM) ? step_reg : ri_reg[sgps_pkg::IDX_W-1:0];
    assign l_rd_idx = (state_reg == ST_SUM) ? step_reg : li_reg[sgps_pkg::IDX_W-1:0];
    assign r_size   = rsizes[r_rd_idx];
    assign l_size   = lsizes[l_rd_idx];

    assign ractive = sgps_pkg::SEG_CNT_W'(step_reg) < rused;
    assign lactive = sgps_pkg::SEG_CNT_W'(step_reg) < lused;

    assign ra     = r_size - ro_reg;
    assign la     = l_size - lo_reg;
    assign tmin   = (ra < la) ? ra : la;
    assign tpiece = (sgps_pkg::OFF_W'(rem_reg) < sgps_pkg::OFF_W'(tmin))
                    ? sgps_pkg::SIZE_BITS'(rem_reg) : tmin;

    assign rend = (sgps_pkg::ADDR_W + 1)'(rstart_reg) + (sgps_pkg::ADDR_W + 1)'(len_reg);
    assign lend = (sgps_pkg::ADDR_W + 1)'(lstart_reg) + (sgps_pkg::ADDR_W + 1)'(len_reg);

    assign r_skip = (ri_reg < rused) && (ro_reg >= r_size);
    assign l_skip = (li_reg < lused) && (lo_reg >= l_size);
    assign cont   = (rem_reg != '0) && (32'(k_reg) < sgps_pkg::MAX_PIECES)
                    && (ri_reg < rused) && (li_reg < lused);

    assign q_pop       = (state_reg == ST_IDLE) && q_valid;
    assign load_remote = q_pop && (q_data.kind == sgps_pkg::CMD_LOAD_REMOTE);
    assign load_local  = q_pop && (q_data.kind == sgps_pkg::CMD_LOAD_LOCAL);

    assign out_load  = (state_reg == ST_PUSH) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_piece = out_piece_reg;

    always_comb
    begin
        state_next  = state_reg;
        dir_next    = dir_reg;
        peer_next   = peer_reg;
        rstart_next = rstart_reg;
        lstart_next = lstart_reg;
        len_next    = len_reg;
        step_next   = step_reg;
        rsum_next   = rsum_reg;
        lsum_next   = lsum_reg;
        rfound_next = rfound_reg;
        lfound_next = lfound_reg;
        rloc_next   = rloc_reg;
        lloc_next   = lloc_reg;
        ri_next     = ri_reg;
        li_next     = li_reg;
        ro_next     = ro_reg;
        lo_next     = lo_reg;
        rem_next    = rem_reg;
        t_next      = t_reg;
        k_next      = k_reg;
        more_next   = more_reg;
        pend_next   = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && (q_data.kind == sgps_pkg::CMD_TRANSFER))
                begin
                    dir_next    = q_data.dir;
                    peer_next   = q_data.peer;
                    rstart_next = q_data.rstart;
                    lstart_next = q_data.lstart;
                    len_next    = q_data.len;
                    step_next   = '0;
                    rsum_next   = '0;
                    lsum_next   = '0;
                    rfound_next = 1'b0;
                    lfound_next = 1'b0;
                    rloc_next   = sgps_pkg::OFF_W'(q_data.rstart);
                    lloc_next   = sgps_pkg::OFF_W'(q_data.lstart);
                    ri_next     = '0;
                    li_next     = '0;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // list totals and offset translation share one pass over the tables
                if (ractive)
                begin
                    rsum_next = rsum_reg + sgps_pkg::SUM_W'(r_size);
                    if (!rfound_reg)
                    begin
                        if (rloc_reg < sgps_pkg::OFF_W'(r_size))
                        begin
                            rfound_next = 1'b1;
                            ri_next     = sgps_pkg::SEG_CNT_W'(step_reg);
                        end
                        else
                        begin
                            rloc_next = rloc_reg - sgps_pkg::OFF_W'(r_size);
                        end
                    end
                end
                if (lactive)
                begin
                    lsum_next = lsum_reg + sgps_pkg::SUM_W'(l_size);
                    if (!lfound_reg)
                    begin
                        if (lloc_reg < sgps_pkg::OFF_W'(l_size))
                        begin
                            lfound_next = 1'b1;
                            li_next     = sgps_pkg::SEG_CNT_W'(step_reg);
                        end
                        else
                        begin
                            lloc_next = lloc_reg - sgps_pkg::OFF_W'(l_size);
                        end
                    end
                end
                if (step_reg == sgps_pkg::IDX_W'(sgps_pkg::MAX_SEGMENTS - 1))
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                pend_next.dir  = dir_reg;
                pend_next.peer = peer_reg;
                pend_next.rseg = '0;
                pend_next.roff = '0;
                pend_next.lseg = '0;
                pend_next.loff = '0;
                pend_next.len  = '0;
                pend_next.last = 1'b1;
                more_next      = 1'b0;
                if (sgps_pkg::CMP_W'(rend) > sgps_pkg::CMP_W'(rsum_reg))
                begin
                    pend_next.status = sgps_pkg::STATUS_OVER_REMOTE;
                    state_next       = ST_PUSH;
                end
                else if (sgps_pkg::CMP_W'(lend) > sgps_pkg::CMP_W'(lsum_reg))
                begin
                    pend_next.status = sgps_pkg::STATUS_OVER_LOCAL;
                    state_next       = ST_PUSH;
                end
                else if (len_reg == '0)
                begin
                    pend_next.status = sgps_pkg::STATUS_ZERO_LENGTH;
                    state_next       = ST_PUSH;
                end
                else
                begin
                    ro_next    = sgps_pkg::SIZE_BITS'(rloc_reg);
                    lo_next    = sgps_pkg::SIZE_BITS'(lloc_reg);
                    rem_next   = len_reg;
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                pend_next.status = sgps_pkg::STATUS_OK;
                pend_next.dir    = dir_reg;
                pend_next.peer   = peer_reg;
                pend_next.rseg   = sgps_pkg::SEG_OUT_W'(ri_reg);
                pend_next.roff   = sgps_pkg::OUT_OFF_W'(ro_reg);
                pend_next.lseg   = sgps_pkg::SEG_OUT_W'(li_reg);
                pend_next.loff   = sgps_pkg::OUT_OFF_W'(lo_reg);
                pend_next.len    = sgps_pkg::OUT_OFF_W'(tpiece);
                pend_next.last   = 1'b0;
                t_next           = tpiece;
                state_next       = ST_ADV;
            end
            ST_ADV:
            begin
                rem_next   = rem_reg - sgps_pkg::ADDR_W'(t_reg);
                ro_next    = ro_reg + t_reg;
                lo_next    = lo_reg + t_reg;
                k_next     = k_reg + 1'b1;
                state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // step past used-up and empty segments, one per cycle on each list
                if (r_skip)
                begin
                    ro_next = '0;
                    ri_next = ri_reg + 1'b1;
                end
                if (l_skip)
                begin
                    lo_next = '0;
                    li_next = li_reg + 1'b1;
                end
                if (!r_skip && !l_skip)
                begin
                    more_next      = cont;
                    pend_next.last = !cont;
                    state_next     = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_load)
                begin
                    state_next = more_reg ? ST_EMIT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rcount_reg    <= sgps_pkg::COUNT_W'(1);
            lcount_reg    <= sgps_pkg::COUNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == sgps_pkg::CFG_REMOTE_COUNT))
            begin
                rcount_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == sgps_pkg::CFG_LOCAL_COUNT))
            begin
                lcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg    <= dir_next;
        peer_reg   <= peer_next;
        rstart_reg <= rstart_next;
        lstart_reg <= lstart_next;
        len_reg    <= len_next;
        step_reg   <= step_next;
        rsum_reg   <= rsum_next;
        lsum_reg   <= lsum_next;
        rfound_reg <= rfound_next;
        lfound_reg <= lfound_next;
        rloc_reg   <= rloc_next;
        lloc_reg   <= lloc_next;
        ri_reg     <= ri_next;
        li_reg     <= li_next;
        ro_reg     <= ro_next;
        lo_reg     <= lo_next;
        rem_reg    <= rem_next;
        t_reg      <= t_next;
        k_reg      <= k_next;
        more_reg   <= more_next;
        pend_reg   <= pend_next;
        if (out_load)
        begin
            out_piece_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_remote)
        begin
            rsizes[sgps_pkg::IDX_W'(q_data.slot)] <= q_data.bytes;
        end
        if (load_local)
        begin
            lsizes[sgps_pkg::IDX_W'(q_data.slot)] <= q_data.bytes;
        end
    end

endmodule
